>>> hw/rtl/sts_pkg.sv
// Package for the servo trapezoid stepper: sizes, reset values, command codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sts_pkg;
  localparam int NUM_JOINTS_D  = 6;
  localparam int ANGLE_MAX_D   = 180;
  localparam int VALUE_CHARS_D = 3;
  localparam int REG_W         = 48;
  localparam int OUT_W         = 64;

  localparam logic [47:0] MIN_RST  = 48'd8839211652108;
  localparam logic [47:0] MAX_RST  = 48'd27638705702440;
  localparam logic [47:0] RAMP_RST = 48'd11046858396687;

  localparam logic [1:0] REG_MIN  = 2'd0;
  localparam logic [1:0] REG_MAX  = 2'd1;
  localparam logic [1:0] REG_RAMP = 2'd2;

  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // per-joint memory word
  typedef struct packed {
    logic [7:0]  pos;
    logic [7:0]  tgt;
    logic [7:0]  steps;
    logic [31:0] last;
  } joint_t;

  typedef struct packed {
    logic        start;
    logic [16:0] num;
    logic [7:0]  den;
  } div_req_t;

  function automatic logic [7:0] pos_init(input int j);
    pos_init = (j == 2) ? 8'd45 : 8'd90;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/sts_div.sv
// Shared restoring divider, one quotient bit per cycle (17 bit by 8 bit).
// Depends on sts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sts_div
  import sts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire div_req_t    req,
  output logic             busy,
  output logic [16:0]      quot
);
  logic [16:0] q_r, q_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [7:0]  den_r, den_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [8:0]  trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; den_nxt = den_r; cnt_nxt = cnt_r;
    trial = {rem_r[7:0], q_r[16]};
    if (req.start) begin
      q_nxt = req.num; rem_nxt = '0; den_nxt = req.den; cnt_nxt = 5'd17;
    end else if (cnt_r != 5'd0) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[15:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[15:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
    q_r <= q_nxt; rem_r <= rem_nxt; den_r <= den_nxt;
  end

  assign busy = (cnt_r != 5'd0) || req.start;
  assign quot = q_r;
endmodule
`default_nettype wire

>>> hw/rtl/servo_trapezoid_stepper.sv
// Servo trapezoid stepper top level: command parser, joint memory, tick sequencer.
// Depends on sts_pkg and sts_div.
//
// Use: in_tuser carries command, in_tdata carries rx_byte. A command of 0
// is a serial byte: it is parsed (joint letter, value characters, comma commits)
// and echoed. A command of 1 is a millisecond tick: every joint is visited in
// turn, its delay computed (in a ramp window by the shared divider), and it steps
// one degree toward its target when the delay has elapsed.
// Each transfer in yields exactly one transfer out carrying echo, all angles
// and the moved mask. A byte goes through read, update and output. A tick goes
// through read, decide and write for each joint, waiting on the serial divider
// between decide and write when a ramp delay needs it, and then through output.
// One item is in flight at a time.
// Reset (synchronous, rst_n low) reloads registers; afterward a clearing pass
// writes reset values into all NUM_JOINTS joint memory words, with in_tready
// low. A result waits in the output register while out_tready is low; the next
// item is not taken until it has gone, at the earliest in the cycle after that.
`timescale 1ns / 1ps
`default_nettype none
module servo_trapezoid_stepper
  import sts_pkg::*;
#(
  parameter int NUM_JOINTS  = NUM_JOINTS_D,
  parameter int ANGLE_MAX   = ANGLE_MAX_D,
  parameter int VALUE_CHARS = VALUE_CHARS_D
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,  // rx_byte[7:0]
  input  wire logic             in_tuser,  // command[0]
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // echo_byte[7:0], pos_base..pos_gripper[55:8], moved_mask[61:56], zero pad
  output logic [OUT_W-1:0]      out_tdata,
  output logic                  out_tuser, // echo_valid[0]
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [REG_W-1:0] cfg_wdata
);
  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int CW = (VALUE_CHARS > 1) ? $clog2(VALUE_CHARS + 1) : 1;

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_BRD   = 9'b000000100,
    S_BWR   = 9'b000001000,
    S_TRD   = 9'b000010000,
    S_TDIV  = 9'b000100000,
    S_TWAIT = 9'b001000000,
    S_TWR   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t st_r, st_nxt;

  logic [REG_W-1:0] min_r, max_r, ramp_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_RST; max_r <= MAX_RST; ramp_r <= RAMP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN:  min_r  <= cfg_wdata;
        REG_MAX:  max_r  <= cfg_wdata;
        REG_RAMP: ramp_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // joint memory, one port, registered read
  joint_t mem [NUM_JOINTS];
  joint_t rd_r;
  logic          mem_we;
  logic [JW-1:0] mem_addr;
  joint_t        mem_wd;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rd_r <= mem[mem_addr];
  end

  // small control state
  logic [JW-1:0] j_r, j_nxt;
  logic [31:0]   time_r, time_nxt;
  logic [2:0]    sel_r, sel_nxt;
  logic [CW-1:0] cc_r, cc_nxt;
  logic [7:0]    buf_r [VALUE_CHARS];
  logic [7:0]    buf_nxt [VALUE_CHARS];
  logic [7:0]    ch_r, ch_nxt;
  logic          cmd_r, cmd_nxt;
  logic [7:0]    pos_r [NUM_JOINTS];
  logic [7:0]    pos_nxt [NUM_JOINTS];
  logic [5:0]    mask_r, mask_nxt;
  logic          ovld_r, ovld_nxt;
  logic [OUT_W-1:0] odata_r, odata_nxt;
  logic          ouser_r, ouser_nxt;
  logic          divd_r, divd_nxt;
  logic [7:0]    base_r, base_nxt;
  logic          sub_r, sub_nxt;

  // register bytes of current joint
  logic [2:0] k;
  logic [7:0] mn, mx, rp;
  assign k  = (32'(j_r) > 5) ? 3'd5 : 3'(j_r);
  assign mn = min_r[k*8 +: 8];
  assign mx = max_r[k*8 +: 8];
  assign rp = ramp_r[k*8 +: 8];

  // delay terms
  logic signed [9:0] dd;
  logic [7:0] gap;
  logic       in_up, in_dn;
  logic [7:0] fac;
  logic [8:0] dabs;
  logic [16:0] prod;
  assign dd    = $signed({2'b0, mx}) - $signed({2'b0, mn});
  assign gap   = (rd_r.pos > rd_r.tgt) ? rd_r.pos - rd_r.tgt : rd_r.tgt - rd_r.pos;
  assign in_up = rd_r.steps < rp;
  assign in_dn = gap < rp;
  assign fac   = in_up ? rd_r.steps : rp - gap;
  assign dabs  = dd[9] ? 9'(-dd) : dd[8:0];
  assign prod  = {8'b0, dabs} * {9'b0, fac};

  div_req_t    dreq;
  logic        dbusy;
  logic [16:0] dq;
  sts_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(dbusy), .quot(dq));

  // parse value
  logic [9:0] val;
  logic       vstop;
  always_comb begin
    val = '0; vstop = 1'b0;
    for (int i = 0; i < VALUE_CHARS; i++) begin
      if (!vstop) begin
        if (buf_r[i] < CH_ZERO || buf_r[i] > CH_NINE) vstop = 1'b1;
        else val = 10'(val * 10) + 10'(buf_r[i] - CH_ZERO);
      end
    end
    if (val > 10'(ANGLE_MAX)) val = 10'(ANGLE_MAX);
  end

  logic signed [11:0] dly;
  logic [10:0] qsig;
  logic [31:0] el;
  joint_t      upd;

  always_comb begin
    st_nxt = st_r; j_nxt = j_r; time_nxt = time_r; sel_nxt = sel_r; cc_nxt = cc_r;
    buf_nxt = buf_r; ch_nxt = ch_r; cmd_nxt = cmd_r; pos_nxt = pos_r; mask_nxt = mask_r;
    ovld_nxt = ovld_r; odata_nxt = odata_r; ouser_nxt = ouser_r; divd_nxt = divd_r;
    base_nxt = base_r; sub_nxt = sub_r;
    mem_we = 1'b0; mem_addr = j_r; mem_wd = rd_r;
    dreq = '0; upd = rd_r;
    qsig = '0;
    dly = '0; el = time_r - rd_r.last;
    in_tready = 1'b0;
    if (ovld_r && out_tready) ovld_nxt = 1'b0;
    case (st_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wd = '{pos: pos_init(32'(j_r)), tgt: 8'd90, steps: 8'd0, last: 32'd0};
        if (32'(j_r) == NUM_JOINTS - 1) begin
          st_nxt = S_IDLE; j_nxt = '0;
        end else j_nxt = j_r + JW'(1);
      end
      S_IDLE: begin
        in_tready = !ovld_r;
        if (in_tvalid && !ovld_r) begin
          cmd_nxt = in_tuser; ch_nxt = in_tdata; mask_nxt = '0;
          if (in_tuser) begin
            time_nxt = time_r + 32'd1; j_nxt = '0; mem_addr = '0; st_nxt = S_TRD;
          end else begin
            mem_addr = JW'(sel_r); st_nxt = S_BRD;
          end
        end
      end
      S_BRD: begin
        mem_addr = JW'(sel_r);
        st_nxt = S_BWR;
      end
      S_BWR: begin
        mem_addr = JW'(sel_r);
        st_nxt = S_OUT;
        case (ch_r)
          CH_B: begin sel_nxt = 3'd0; cc_nxt = '0; end
          CH_S: begin sel_nxt = 3'd1; cc_nxt = '0; end
          CH_E: begin sel_nxt = 3'd2; cc_nxt = '0; end
          CH_W: begin sel_nxt = 3'd3; cc_nxt = '0; end
          CH_X: begin sel_nxt = 3'd4; cc_nxt = '0; end
          CH_G: begin sel_nxt = 3'd5; cc_nxt = '0; end
          CH_COMMA: begin
            if (32'(sel_r) < NUM_JOINTS && val[7:0] != rd_r.tgt) begin
              mem_we = 1'b1;
              mem_wd.tgt = val[7:0];
              mem_wd.steps = '0;
            end
            for (int i = 0; i < VALUE_CHARS; i++) buf_nxt[i] = CH_ZERO;
            cc_nxt = '0;
          end
          default: begin
            if (32'(cc_r) < VALUE_CHARS) begin
              for (int i = 0; i < VALUE_CHARS; i++)
                if (32'(cc_r) == i) buf_nxt[i] = ch_r;
              cc_nxt = cc_r + CW'(1);
            end
          end
        endcase
      end
      S_TRD: st_nxt = S_TDIV;
      S_TDIV: begin
        // flat delay unless a ramp window applies
        divd_nxt = 1'b0; base_nxt = mn; sub_nxt = 1'b0;
        if (rd_r.pos == rd_r.tgt) begin
          st_nxt = S_TWR;
        end else if (rp != 8'd0 && (in_up || in_dn)) begin
          dreq.start = 1'b1; dreq.num = prod; dreq.den = rp;
          sub_nxt = in_up ^ dd[9];
          base_nxt = in_up ? mx : mn;
          divd_nxt = 1'b1;
          st_nxt = S_TWAIT;
        end else begin
          st_nxt = S_TWR;
        end
      end
      S_TWAIT: if (!dbusy) st_nxt = S_TWR;
      S_TWR: begin
        qsig = divd_r ? dq[10:0] : 11'd0;
        dly = sub_r ? 12'($signed({4'b0, base_r})) - $signed({1'b0, qsig})
                    : 12'($signed({4'b0, base_r})) + $signed({1'b0, qsig});
        if (rd_r.pos == rd_r.tgt) begin
          mem_we = 1'b1; mem_wd.steps = '0;
        end else if (el >= 32'(dly)) begin
          mem_we = 1'b1;
          upd.last = time_r;
          upd.pos = (rd_r.pos < rd_r.tgt) ? rd_r.pos + 8'd1 : rd_r.pos - 8'd1;
          if (rd_r.steps != 8'd255) upd.steps = rd_r.steps + 8'd1;
          mem_wd = upd;
          pos_nxt[j_r] = upd.pos;
          if (32'(j_r) < 6) mask_nxt[3'(j_r)] = 1'b1;
        end
        // write-back goes to j_r; next joint is read in S_TRD
        if (32'(j_r) == NUM_JOINTS - 1) begin
          st_nxt = S_OUT;
        end else begin
          j_nxt = j_r + JW'(1); st_nxt = S_TRD;
        end
      end
      S_OUT: begin
        if (!ovld_r) begin
          odata_nxt = '0;
          ouser_nxt = !cmd_r;
          odata_nxt[7:0] = cmd_r ? 8'd0 : ch_r;
          for (int i = 0; i < 6; i++)
            if (i < NUM_JOINTS) odata_nxt[8 + 8*i +: 8] = pos_r[i];
          odata_nxt[61:56] = mask_r;
          ovld_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; j_r <= '0; time_r <= '0; sel_r <= '0; cc_r <= '0;
      for (int i = 0; i < VALUE_CHARS; i++) buf_r[i] <= CH_ZERO;
      for (int i = 0; i < NUM_JOINTS; i++) pos_r[i] <= pos_init(i);
      ovld_r <= 1'b0; mask_r <= '0;
    end else begin
      st_r <= st_nxt; j_r <= j_nxt; time_r <= time_nxt; sel_r <= sel_nxt;
      cc_r <= cc_nxt; buf_r <= buf_nxt; pos_r <= pos_nxt; ovld_r <= ovld_nxt;
      mask_r <= mask_nxt;
    end
    ch_r <= ch_nxt; cmd_r <= cmd_nxt; odata_r <= odata_nxt; ouser_r <= ouser_nxt;
    divd_r <= divd_nxt; base_r <= base_nxt; sub_r <= sub_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  // no new transfer while a result is held
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready) else $error("input taken while output held");
  // a tick advances time by one
  a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE && in_tvalid && in_tready && in_tuser) |=> time_r == $past(time_r) + 32'd1)
    else $error("time not advanced");
  // clearing pass blocks input
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_CLR |-> !in_tready) else $error("input during clear");
endmodule
`default_nettype wire
